FILE: hw/rtl/hcw_pkg.sv
// ----------------------------------------------------------------------------
// hcw_pkg
// Shared types and constants for the heartbeat cross-check watchdog.
// ----------------------------------------------------------------------------
package hcw_pkg;

    localparam int DUTY_W   = 16;
    localparam int TMO_W    = 20;
    localparam int HOLD_W   = 22;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [DUTY_W-1:0] DUTY_RST = 16'd500;
    localparam logic [TMO_W-1:0]  TMO_RST  = 20'd5000;
    localparam logic [HOLD_W-1:0] HOLD_RST = 22'd1000000;

    localparam logic [DUTY_W-1:0] TOGGLE_MAX = '1;
    localparam logic [TMO_W-1:0]  ECHO_MAX   = '1;

    // register index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_DUTY    = 2'd0,
        REG_TIMEOUT = 2'd1,
        REG_HOLDOFF = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_time;
        logic [TMO_W-1:0]  echo_timeout;
        logic [HOLD_W-1:0] start_holdoff;
    } cfg_t;

    typedef struct packed {
        logic enable_out;
        logic host_transmit;
        logic client_transmit;
        logic estop_latched;
    } result_t;

endpackage

FILE: hw/rtl/hcw_regs.sv
// ----------------------------------------------------------------------------
// hcw_regs
// APB register file: duty time, echo timeout, start hold-off.
// ----------------------------------------------------------------------------
module hcw_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hcw_pkg::PADDR_W-1:0]  paddr,
    input  logic [hcw_pkg::PDATA_W-1:0]  pwdata,
    output logic [hcw_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output hcw_pkg::cfg_t                cfg
);
    import hcw_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.duty_time     <= DUTY_RST;
            cfg_reg.echo_timeout  <= TMO_RST;
            cfg_reg.start_holdoff <= HOLD_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_DUTY:    cfg_reg.duty_time     <= pwdata[DUTY_W-1:0];
                REG_TIMEOUT: cfg_reg.echo_timeout  <= pwdata[TMO_W-1:0];
                REG_HOLDOFF: cfg_reg.start_holdoff <= pwdata[HOLD_W-1:0];
                default: ;  // unmapped slot, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_DUTY:    prdata = {{(PDATA_W-DUTY_W){1'b0}}, cfg_reg.duty_time};
            REG_TIMEOUT: prdata = {{(PDATA_W-TMO_W){1'b0}}, cfg_reg.echo_timeout};
            REG_HOLDOFF: prdata = {{(PDATA_W-HOLD_W){1'b0}}, cfg_reg.start_holdoff};
            default:     prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/hcw_core.sv
// ----------------------------------------------------------------------------
// hcw_core
// Watchdog state: hold-off, heartbeat toggle timer, echo timer, e-stop latch.
// Result for the current tick is produced combinationally from next state.
// ----------------------------------------------------------------------------
module hcw_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             tick,
    input  logic             host_echo,
    input  logic             client_receive,
    input  hcw_pkg::cfg_t    cfg,
    output hcw_pkg::result_t res
);
    import hcw_pkg::*;

    logic [HOLD_W-1:0] hold_reg,   hold_next;
    logic [DUTY_W-1:0] toggle_reg, toggle_next;
    logic [TMO_W-1:0]  echo_reg,   echo_next;
    logic              last_echo_reg, last_echo_next;
    logic              hb_reg,        hb_next;
    logic              echo_lvl_reg,  echo_lvl_next;
    logic              enable_reg,    enable_next;
    logic              stop_reg,      stop_next;

    logic [DUTY_W-1:0] toggle_inc;
    logic [TMO_W-1:0]  echo_inc;
    logic              expired;

    always_comb begin
        hold_next      = hold_reg;
        toggle_next    = toggle_reg;
        echo_next      = echo_reg;
        last_echo_next = last_echo_reg;
        hb_next        = hb_reg;
        echo_lvl_next  = echo_lvl_reg;
        enable_next    = enable_reg;
        stop_next      = stop_reg;

        toggle_inc = toggle_reg + 1'b1;
        expired    = (toggle_reg == TOGGLE_MAX) || (toggle_inc == TOGGLE_MAX)
                     || (toggle_inc > cfg.duty_time);
        echo_inc   = (echo_reg == ECHO_MAX) ? echo_reg : echo_reg + 1'b1;

        if (!stop_reg) begin
            echo_lvl_next = client_receive;
            if (hold_reg < cfg.start_holdoff) begin
                hold_next      = hold_reg + 1'b1;
                last_echo_next = host_echo;
                echo_next      = '0;
            end else begin
                if (expired) begin
                    hb_next     = ~hb_reg;
                    toggle_next = '0;
                end else begin
                    toggle_next = toggle_inc;
                end
                echo_next = echo_inc;
                if (host_echo != last_echo_reg) begin
                    last_echo_next = host_echo;
                    echo_next      = '0;
                    enable_next    = 1'b1;
                end else if (echo_inc == ECHO_MAX || echo_inc > cfg.echo_timeout) begin
                    stop_next     = 1'b1;
                    enable_next   = 1'b0;
                    hb_next       = 1'b0;
                    echo_lvl_next = 1'b0;
                end
            end
        end

        res.enable_out      = enable_next   && !stop_next;
        res.host_transmit   = hb_next       && !stop_next;
        res.client_transmit = echo_lvl_next && !stop_next;
        res.estop_latched   = stop_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg      <= '0;
            toggle_reg    <= TOGGLE_MAX;
            echo_reg      <= '0;
            last_echo_reg <= 1'b0;
            hb_reg        <= 1'b0;
            echo_lvl_reg  <= 1'b0;
            enable_reg    <= 1'b0;
            stop_reg      <= 1'b0;
        end else if (tick) begin
            hold_reg      <= hold_next;
            toggle_reg    <= toggle_next;
            echo_reg      <= echo_next;
            last_echo_reg <= last_echo_next;
            hb_reg        <= hb_next;
            echo_lvl_reg  <= echo_lvl_next;
            enable_reg    <= enable_next;
            stop_reg      <= stop_next;
        end
    end

`ifndef SYNTH
    // e-stop is sticky until reset
    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stop_reg |=> stop_reg)
        else $error("e-stop latch released");

    // a latched stop drives all lines low
    a_stop_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        stop_reg |-> (!enable_reg && !hb_reg && !echo_lvl_reg))
        else $error("line high while stopped");

    // a heartbeat toggle restarts the toggle timer
    a_toggle_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (!stop_reg && hb_reg != $past(hb_reg)) |-> (toggle_reg == '0))
        else $error("toggle timer not restarted");
`endif

endmodule

FILE: hw/rtl/heartbeat_crosscheck_watchdog.sv
// ----------------------------------------------------------------------------
// heartbeat_crosscheck_watchdog
// Heartbeat watchdog with latched e-stop, one result item per tick item.
// ----------------------------------------------------------------------------
// Usage:
//   Each s_ item is one microsecond tick carrying the sampled host echo and
//   client receive levels. Each item yields exactly one m_ item with enable,
//   host transmit, client transmit and e-stop status for that tick.
//   The result is captured in the output register on the edge that accepts
//   the item. Throughput: one item per cycle while m_ready stays high; the state
//   update is a single pass of counter increment and compare logic between
//   the state registers and the output register.
//   Stall: while m_valid is high and m_ready low, the output register holds
//   and s_ready drops; when the receiver takes the item, a new one can be
//   accepted in that same cycle.
//   Reset (aresetn low, synchronous): registers return to duty 500, timeout
//   5000, hold-off 1000000; counters clear, toggle timer starts expired so
//   the first toggle comes on the first tick after the hold-off.
//   Config via APB: 0x0 duty_time, 0x4 echo_timeout, 0x8 start_holdoff.
//   Write only while no item is in flight.
// ----------------------------------------------------------------------------
module heartbeat_crosscheck_watchdog (
    input  logic                         aclk,
    input  logic                         aresetn,
    // tick items
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_host_echo,
    input  logic                         s_client_receive,
    // result items
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_enable_out,
    output logic                         m_host_transmit,
    output logic                         m_client_transmit,
    output logic                         m_estop_latched,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hcw_pkg::PADDR_W-1:0]  paddr,
    input  logic [hcw_pkg::PDATA_W-1:0]  pwdata,
    output logic [hcw_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import hcw_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t out_reg;
    logic    m_valid_reg;
    logic    s_accept;

    // output register frees when empty or being drained
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    hcw_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hcw_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .tick           (s_accept),
        .host_echo      (s_host_echo),
        .client_receive (s_client_receive),
        .cfg            (cfg),
        .res            (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_reg <= res;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_enable_out      = out_reg.enable_out;
    assign m_host_transmit   = out_reg.host_transmit;
    assign m_client_transmit = out_reg.client_transmit;
    assign m_estop_latched   = out_reg.estop_latched;

`ifndef SYNTH
    // a held result is never replaced
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(out_reg)))
        else $error("stalled result overwritten");

    // an accepted item always leaves a result in the register
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid)
        else $error("accepted item lost");

    // e-stop status excludes any high line
    a_stop_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_estop_latched) |->
            (!m_enable_out && !m_host_transmit && !m_client_transmit))
        else $error("line high with e-stop set");
`endif

endmodule

FILE: sim/heartbeat_crosscheck_watchdog_tb.sv
// ----------------------------------------------------------------------------
// heartbeat_crosscheck_watchdog_tb
// Self-checking bench for the heartbeat watchdog with latched e-stop.
// A directed table covers reset values, hold-off entry and exit, register
// masking and the counter extremes. Randomized phases follow, each under a
// fresh register setting. The run closes with an idle-free run at the largest
// duty and timeout and a forced e-stop. Every result item is checked against
// a tick-level predictor, or the typed value of its table row.
// ----------------------------------------------------------------------------
module heartbeat_crosscheck_watchdog_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hcw_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    // paddr[3:2] == 3 decodes to no register
    localparam logic [1:0]  REG_UNUSED  = 2'd3;

    typedef enum logic [1:0] {
        ROW_TICK,
        ROW_WRITE,
        ROW_READ
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  idx;
        logic [31:0] data;
        logic        echo;
        logic        recv;
        bit          typed;
        result_t     want;
    } row_t;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_host_echo;
    logic               s_client_receive;
    logic               m_valid;
    logic               m_ready;
    logic               m_enable_out;
    logic               m_host_transmit;
    logic               m_client_transmit;
    logic               m_estop_latched;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // ------------------------------------------------------------------------
    // Watchdog predictor state: a private copy of the registers and counters
    // ------------------------------------------------------------------------
    cfg_t              cfg;
    logic [HOLD_W-1:0] ho_count;
    logic [DUTY_W-1:0] tog_elapsed;
    logic [TMO_W-1:0]  echo_age;
    logic              prev_echo;
    logic              hb_level;
    logic              rx_level;
    logic              en_level;
    logic              estop;

    result_t     expected_outputs[$];
    row_t        stim_rows[$];

    int          fail_count;
    int          ticks_sent;
    int          results_checked;
    int          reg_writes;
    int unsigned cycle_count;

    // traffic shaping, shared between the sender and receiver processes
    bit          idle_on;
    int          tx_gap_pct;
    bit          rx_hold_req;

    heartbeat_crosscheck_watchdog u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_host_echo       (s_host_echo),
        .s_client_receive  (s_client_receive),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_enable_out      (m_enable_out),
        .m_host_transmit   (m_host_transmit),
        .m_client_transmit (m_client_transmit),
        .m_estop_latched   (m_estop_latched),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic result_t outs(input logic en, input logic hb, input logic ct,
                                     input logic es);
        result_t r;
        r.enable_out      = en;
        r.host_transmit   = hb;
        r.client_transmit = ct;
        r.estop_latched   = es;
        return r;
    endfunction

    // One tick of the watchdog: updates the private state, returns the outputs.
    function automatic result_t predict_tick(input logic echo, input logic recv);
        logic expired;
        if (!estop) begin
            rx_level = recv;
            if (ho_count < cfg.start_holdoff) begin
                // hold-off: only track the echo level, keep the echo timer clear
                ho_count  = ho_count + 1'b1;
                prev_echo = echo;
                echo_age  = '0;
            end else begin
                // a saturated toggle timer counts as expired
                expired = (tog_elapsed == TOGGLE_MAX);
                if (!expired) begin
                    tog_elapsed = tog_elapsed + 1'b1;
                    expired = (tog_elapsed == TOGGLE_MAX) || (tog_elapsed > cfg.duty_time);
                end
                if (expired) begin
                    hb_level    = ~hb_level;
                    tog_elapsed = '0;
                end
                if (echo_age != ECHO_MAX)
                    echo_age = echo_age + 1'b1;
                if (echo != prev_echo) begin
                    prev_echo = echo;
                    echo_age  = '0;
                    en_level  = 1'b1;
                end else if (echo_age == ECHO_MAX || echo_age > cfg.echo_timeout) begin
                    // latched until reset
                    estop    = 1'b1;
                    en_level = 1'b0;
                    hb_level = 1'b0;
                    rx_level = 1'b0;
                end
            end
        end
        if (estop)
            return outs(1'b0, 1'b0, 1'b0, 1'b1);
        return outs(en_level, hb_level, rx_level, 1'b0);
    endfunction

    // Echo level for the next tick. Forces a change when leaving the echo
    // unchanged would trip the e-stop, so random phases stay out of the stop.
    function automatic logic pick_echo(input int unsigned chg_div);
        if (!estop && ho_count >= cfg.start_holdoff &&
            ({1'b0, echo_age} + 21'd1) > {1'b0, cfg.echo_timeout})
            return ~prev_echo;
        return ($urandom_range(1, chg_div) == 1) ? ~prev_echo : prev_echo;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------------
    function automatic void tick_row(input logic echo, input logic recv);
        row_t r;
        r.kind  = ROW_TICK;
        r.idx   = '0;
        r.data  = '0;
        r.echo  = echo;
        r.recv  = recv;
        r.typed = 1'b0;
        r.want  = '0;
        stim_rows.push_back(r);
    endfunction

    function automatic void tick_row_exp(input logic echo, input logic recv,
                                         input result_t want);
        row_t r;
        r.kind  = ROW_TICK;
        r.idx   = '0;
        r.data  = '0;
        r.echo  = echo;
        r.recv  = recv;
        r.typed = 1'b1;
        r.want  = want;
        stim_rows.push_back(r);
    endfunction

    function automatic void reg_row(input row_kind_t kind, input logic [1:0] idx,
                                    input logic [31:0] data);
        row_t r;
        r.kind  = kind;
        r.idx   = idx;
        r.data  = data;
        r.echo  = 1'b0;
        r.recv  = 1'b0;
        r.typed = 1'b0;
        r.want  = '0;
        stim_rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Bus tasks
    // ------------------------------------------------------------------------
    // Stop offering ticks and wait until every predicted result has arrived.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_outputs.size() != 0);
    endtask

    task automatic read_reg(input logic [1:0] idx, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // access phase, pready tied high: prdata valid at this edge
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // APB write, mirrored into the predictor config, then read back masked.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        logic [31:0] rb;
        logic [31:0] want_rb;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        reg_writes++;
        want_rb = '0;
        case (idx)
            REG_DUTY: begin
                cfg.duty_time = data[DUTY_W-1:0];
                want_rb = 32'(cfg.duty_time);
            end
            REG_TIMEOUT: begin
                cfg.echo_timeout = data[TMO_W-1:0];
                want_rb = 32'(cfg.echo_timeout);
            end
            REG_HOLDOFF: begin
                cfg.start_holdoff = data[HOLD_W-1:0];
                want_rb = 32'(cfg.start_holdoff);
            end
            default: ;
        endcase
        if (idx != REG_UNUSED) begin
            read_reg(idx, rb);
            if (rb !== want_rb) begin
                $error("prdata reg %0d: expected %h, got %h", idx, want_rb, rb);
                fail_count++;
            end
        end
    endtask

    // Offer one tick item, with an optional random gap first. The prediction
    // is made at the accepting edge; a typed row overrides the predicted value.
    task automatic send_tick(input logic echo, input logic recv,
                             input bit typed = 1'b0, input result_t want = '0);
        result_t pred;
        if (idle_on && $urandom_range(0, 99) < tx_gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_host_echo      <= echo;
        s_client_receive <= recv;
        do @(posedge aclk); while (!s_ready);
        pred = predict_tick(echo, recv);
        expected_outputs.push_back(typed ? want : pred);
        ticks_sent++;
    endtask

    // New register setting per random phase, upper data bits filled with
    // junk to exercise the width masks.
    task automatic random_setting();
        logic [31:0] d;
        logic [31:0] t;
        logic [31:0] h;
        case ($urandom_range(0, 5))
            0:       d = 0;
            1:       d = 1;
            2:       d = $urandom_range(2, 8);
            3:       d = $urandom_range(9, 40);
            4:       d = 65535;
            default: d = $urandom_range(1, 300);
        endcase
        case ($urandom_range(0, 5))
            0:       t = 0;
            1:       t = 1;
            2:       t = $urandom_range(2, 10);
            3:       t = $urandom_range(11, 60);
            4:       t = 1048575;
            default: t = $urandom_range(61, 1048575);
        endcase
        case ($urandom_range(0, 7))
            0, 1:    h = 0;
            2: begin
                // re-enter hold-off for a few ticks past the current count
                h = 32'(ho_count) + $urandom_range(1, 30);
                if (h > 32'h003F_FFFF)
                    h = 32'h003F_FFFF;
            end
            3:       h = 32'h003F_FFFF;
            default: h = $urandom_range(0, 20);
        endcase
        drain_results();
        write_reg(REG_DUTY,    d | ($urandom() & 32'hFFFF_0000));
        write_reg(REG_TIMEOUT, t | ($urandom() & 32'hFFF0_0000));
        write_reg(REG_HOLDOFF, h | ($urandom() & 32'hFFC0_0000));
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, $urandom());
    endtask

    // ------------------------------------------------------------------------
    // Result checker: oldest prediction against each accepted result item
    // ------------------------------------------------------------------------
    task automatic check_outputs(input result_t want, input result_t got);
        if (got.enable_out !== want.enable_out) begin
            $error("enable_out: expected %0b, got %0b", want.enable_out, got.enable_out);
            fail_count++;
        end
        if (got.host_transmit !== want.host_transmit) begin
            $error("host_transmit: expected %0b, got %0b",
                   want.host_transmit, got.host_transmit);
            fail_count++;
        end
        if (got.client_transmit !== want.client_transmit) begin
            $error("client_transmit: expected %0b, got %0b",
                   want.client_transmit, got.client_transmit);
            fail_count++;
        end
        if (got.estop_latched !== want.estop_latched) begin
            $error("estop_latched: expected %0b, got %0b",
                   want.estop_latched, got.estop_latched);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_outputs.size() == 0) begin
                $error("result item with no tick item pending");
                fail_count++;
            end else begin
                check_outputs(expected_outputs.pop_front(),
                              outs(m_enable_out, m_host_transmit,
                                   m_client_transmit, m_estop_latched));
                results_checked++;
            end
        end
    end

    // Watchdog on the bench itself
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("cycle limit hit, %0d results still pending", expected_outputs.size());
            $display("FAIL heartbeat_crosscheck_watchdog");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready stalls, long ready stretches, and one long
    // hold-off on request so the block backs up into its input.
    // ------------------------------------------------------------------------
    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                rx_hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < 30) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            if (idle_on)
                repeat (($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 12))
                    @(posedge aclk);
            else
                @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // Sender / sequencer
    // ------------------------------------------------------------------------
    initial begin
        row_t        row;
        logic [31:0] rb;
        int unsigned chg_div;

        // every input known from time zero
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_host_echo      = 1'b0;
        s_client_receive = 1'b0;
        m_ready          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        fail_count       = 0;
        ticks_sent       = 0;
        results_checked  = 0;
        reg_writes       = 0;
        cycle_count      = 0;
        idle_on          = 1'b1;
        tx_gap_pct       = 25;
        rx_hold_req      = 1'b0;

        // predictor at its reset point
        cfg.duty_time     = DUTY_RST;
        cfg.echo_timeout  = TMO_RST;
        cfg.start_holdoff = HOLD_RST;
        ho_count          = '0;
        tog_elapsed       = TOGGLE_MAX;
        echo_age          = '0;
        prev_echo         = 1'b0;
        hb_level          = 1'b0;
        rx_level          = 1'b0;
        en_level          = 1'b0;
        estop             = 1'b0;

        // ---- directed table ----
        // reset values of the registers
        reg_row(ROW_READ, REG_DUTY,    32'(DUTY_RST));
        reg_row(ROW_READ, REG_TIMEOUT, 32'(TMO_RST));
        reg_row(ROW_READ, REG_HOLDOFF, 32'(HOLD_RST));
        // inside the reset hold-off: only client transmit moves
        tick_row_exp(1'b0, 1'b0, outs(1'b0, 1'b0, 1'b0, 1'b0));
        tick_row_exp(1'b1, 1'b1, outs(1'b0, 1'b0, 1'b1, 1'b0));
        tick_row_exp(1'b0, 1'b1, outs(1'b0, 1'b0, 1'b1, 1'b0));
        // hold-off ends: first toggle at once, echo change raises enable
        reg_row(ROW_WRITE, REG_HOLDOFF, 32'd0);
        tick_row_exp(1'b1, 1'b0, outs(1'b1, 1'b1, 1'b0, 1'b0));
        // zero duty: heartbeat toggles every tick
        reg_row(ROW_WRITE, REG_DUTY, 32'd0);
        tick_row(1'b1, 1'b1);
        tick_row(1'b0, 1'b0);
        tick_row(1'b0, 1'b1);
        tick_row(1'b1, 1'b0);
        // all-ones writes land as the field maximum
        reg_row(ROW_WRITE, REG_DUTY,    32'hFFFF_FFFF);
        reg_row(ROW_WRITE, REG_TIMEOUT, 32'hFFFF_FFFF);
        tick_row(1'b0, 1'b1);
        tick_row(1'b0, 1'b0);
        tick_row(1'b1, 1'b1);
        // write to an undecoded address is dropped
        reg_row(ROW_WRITE, REG_UNUSED, 32'h1234_5678);
        // tight timing: echo age walks up to the timeout without crossing it
        reg_row(ROW_WRITE, REG_DUTY,    32'd1);
        reg_row(ROW_WRITE, REG_TIMEOUT, 32'd2);
        tick_row(1'b0, 1'b0);
        tick_row(1'b0, 1'b1);
        tick_row(1'b0, 1'b0);
        tick_row(1'b1, 1'b1);
        tick_row(1'b1, 1'b0);
        // largest hold-off re-enters hold-off; only client transmit still moves
        reg_row(ROW_WRITE, REG_HOLDOFF, 32'hFFFF_FFFF);
        tick_row(1'b1, 1'b1);
        tick_row(1'b0, 1'b0);
        tick_row(1'b1, 1'b0);
        reg_row(ROW_WRITE, REG_HOLDOFF, 32'd0);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < stim_rows.size(); i++) begin
            row = stim_rows[i];
            case (row.kind)
                ROW_TICK: send_tick(row.echo, row.recv, row.typed, row.want);
                ROW_WRITE: begin
                    drain_results();
                    write_reg(row.idx, row.data);
                end
                default: begin
                    drain_results();
                    read_reg(row.idx, rb);
                    if (rb !== row.data) begin
                        $error("prdata reg %0d: expected %h, got %h", row.idx, row.data, rb);
                        fail_count++;
                    end
                end
            endcase
        end

        // ---- random phases, each under its own setting ----
        for (int ph = 0; ph < 11; ph++) begin
            random_setting();
            tx_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            chg_div    = $urandom_range(1, 8);
            // long receiver hold-off while ticks keep coming
            if (ph == 3)
                rx_hold_req = 1'b1;
            for (int k = 0; k < 150; k++) begin
                // sender pause until the pipe is empty
                if (ph == 6 && k == 75)
                    drain_results();
                send_tick(pick_echo(chg_div), 1'($urandom_range(0, 1)));
            end
        end

        // ---- closing part, no idling ----
        // largest duty and timeout, ticks back to back
        idle_on = 1'b0;
        drain_results();
        write_reg(REG_DUTY,    32'd65535);
        write_reg(REG_TIMEOUT, 32'd1048575);
        write_reg(REG_HOLDOFF, 32'd0);
        for (int k = 0; k < 100; k++)
            send_tick(pick_echo(500), 1'($urandom_range(0, 1)));

        // zero timeout: stop latches on the first tick without a change
        drain_results();
        write_reg(REG_DUTY,    32'd3);
        write_reg(REG_TIMEOUT, 32'd0);
        for (int k = 0; k < 6; k++)
            send_tick(~prev_echo, 1'($urandom_range(0, 1)));
        send_tick(prev_echo, 1'b1);
        // latched: nothing moves any more
        for (int k = 0; k < 40; k++)
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

        drain_results();
        repeat (4) @(posedge aclk);

        $display("Run: %0d tick items, %0d results checked, %0d register writes",
                 ticks_sent, results_checked, reg_writes);
        $display("Covered hold-off re-entry, duty/timeout extremes, long stall, e-stop=%0b",
                 estop);
        if (fail_count == 0)
            $display("PASS heartbeat_crosscheck_watchdog");
        else
            $display("FAIL heartbeat_crosscheck_watchdog");
        $finish;
    end

endmodule
